// ----- design/bsah_pkg.sv -----
package bsah_pkg;

  localparam int CW         = 16;             // center width
  localparam int RAD_W      = CW - 1;
  localparam int BOX_W      = CW + 1;
  localparam int DIM_W      = BOX_W + 1;
  localparam int POS_W      = CW + 4;
  localparam int CMP_W      = CW + 6;         // 8*center and plane position
  localparam int DEPTH_W    = 6;
  localparam int CNT_OUT_W  = 11;
  localparam int AXIS_W     = 2;
  localparam int SPLIT_BINS = 8;
  localparam int BIN_SH     = $clog2(SPLIT_BINS);
  localparam int PLANE_W    = BIN_SH;
  localparam int SPH_W      = 3 * CW + RAD_W;
  localparam int AREA_W     = 2 * DIM_W + 2;
  localparam int COST_W     = 64;
  localparam int EV_STEP_W  = 4;
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST = DEPTH_W'(40);
  localparam logic [AXIS_W-1:0]   AXIS_LAST     = AXIS_W'(2);
  localparam logic [PLANE_W-1:0]  PLANE_LAST    = PLANE_W'(SPLIT_BINS - 1);
  localparam logic [EV_STEP_W-1:0] EV_STEP_LAST = EV_STEP_W'(8);

  typedef enum logic [2:0] {
    ST_LOAD, ST_DECIDE, ST_PLANE, ST_SCAN, ST_DRAIN, ST_EVAL, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE, EV_MAC, EV_COST, EV_CMP
  } ev_op_t;

  typedef struct packed {
    logic                load;
    logic                plane_start;
    logic                rd_en;
    logic [AXIS_W-1:0]   axis;
    logic [PLANE_W-1:0]  plane;
    ev_op_t              ev_op;
    logic                ev_side;
    logic [1:0]          ev_term;
    logic                emit;
  } cmd_t;

  typedef struct packed {
    logic leaf;
    logic out_free;
  } status_t;

  function automatic logic signed [BOX_W-1:0] sph_lo(logic signed [CW-1:0] c,
                                                     logic [RAD_W-1:0] r);
    return BOX_W'(c) - $signed({2'b00, r});
  endfunction

  function automatic logic signed [BOX_W-1:0] sph_hi(logic signed [CW-1:0] c,
                                                     logic [RAD_W-1:0] r);
    return BOX_W'(c) + $signed({2'b00, r});
  endfunction

endpackage

// ----- design/bsah_in_if.sv -----
interface bsah_in_if import bsah_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [CW-1:0]      center_x;
  logic signed [CW-1:0]      center_y;
  logic signed [CW-1:0]      center_z;
  logic [RAD_W-1:0]          radius;
  logic [DEPTH_W-1:0]        node_depth;
  logic                      last;

  modport source (output valid, center_x, center_y, center_z, radius, node_depth, last,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, radius, node_depth, last,
                output ready);
endinterface

// ----- design/bsah_out_if.sv -----
interface bsah_out_if import bsah_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      is_leaf;
  logic                      split_found;
  logic [AXIS_W-1:0]         split_axis;
  logic signed [POS_W-1:0]   split_pos_x8;
  logic signed [BOX_W-1:0]   box_min_x;
  logic signed [BOX_W-1:0]   box_min_y;
  logic signed [BOX_W-1:0]   box_min_z;
  logic signed [BOX_W-1:0]   box_max_x;
  logic signed [BOX_W-1:0]   box_max_y;
  logic signed [BOX_W-1:0]   box_max_z;
  logic [CNT_OUT_W-1:0]      node_count;

  modport source (output valid, is_leaf, split_found, split_axis, split_pos_x8,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  node_count, input ready);
  modport sink (input valid, is_leaf, split_found, split_axis, split_pos_x8,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                node_count, output ready);
endinterface

// ----- design/bsah_ctrl.sv -----
module bsah_ctrl import bsah_pkg::*; #(
  parameter int AW    = 10,
  parameter int CNT_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  status_t          st,
  input  logic [CNT_W-1:0] cnt,
  output cmd_t             cmd,
  output logic [AW-1:0]    rd_addr
);

  state_t               state, state_next;
  logic [AXIS_W-1:0]    axis, axis_next;
  logic [PLANE_W-1:0]   plane, plane_next;
  logic [AW-1:0]        k, k_next;
  logic [EV_STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      axis  <= '0;
      plane <= '0;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      plane <= plane_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    plane_next  = plane;
    k_next      = k;
    step_next   = step;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.ev_op   = EV_NONE;
    cmd.axis    = axis;
    cmd.plane   = plane;
    rd_addr     = k;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.leaf) begin
          state_next = ST_EMIT;
        end else begin
          axis_next  = '0;
          plane_next = PLANE_W'(1);
          state_next = ST_PLANE;
        end
      end
      ST_PLANE: begin
        cmd.plane_start = 1'b1;
        k_next          = '0;
        state_next      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (CNT_W'(k) + CNT_W'(1) == cnt) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k + AW'(1);
        end
      end
      ST_DRAIN: begin
        // last read word is folded into the side boxes at the end of this cycle
        step_next  = '0;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (step < EV_STEP_W'(6)) begin
          cmd.ev_op   = EV_MAC;
          cmd.ev_side = (step >= EV_STEP_W'(3));
          cmd.ev_term = (step >= EV_STEP_W'(3)) ? 2'(step - EV_STEP_W'(3)) : 2'(step);
        end else if (step < EV_STEP_LAST) begin
          cmd.ev_op   = EV_COST;
          cmd.ev_side = (step == EV_STEP_W'(7));
        end else begin
          cmd.ev_op   = EV_CMP;
        end
        if (step == EV_STEP_LAST) begin
          if (plane == PLANE_LAST) begin
            if (axis == AXIS_LAST) begin
              state_next = ST_EMIT;
            end else begin
              axis_next  = axis + AXIS_W'(1);
              plane_next = PLANE_W'(1);
              state_next = ST_PLANE;
            end
          end else begin
            plane_next = plane + PLANE_W'(1);
            state_next = ST_PLANE;
          end
        end else begin
          step_next = step + EV_STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  a_emit_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == ST_LOAD)
    else $error("emit not followed by load state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(k) < cnt)
    else $error("scan address beyond loaded count");

  a_split_needs_two: assert property (@(posedge clk) disable iff (rst)
    state == ST_PLANE |-> cnt >= CNT_W'(2))
    else $error("split search on fewer than two spheres");

endmodule

// ----- design/bsah_dp.sv -----
module bsah_dp import bsah_pkg::*; #(
  parameter int MAX_SPHERES = 1024,
  parameter int AW          = 10,
  parameter int CNT_W       = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [DEPTH_W-1:0]   cfg_wr_data,
  bsah_in_if.sink              sph,
  bsah_out_if.source           res,
  input  cmd_t                 cmd,
  input  logic [AW-1:0]        rd_addr,
  output status_t              st,
  output logic [CNT_W-1:0]     cnt
);

  logic [DEPTH_W-1:0]      max_depth;
  logic [DEPTH_W-1:0]      depth_held;
  logic [SPH_W-1:0]        mem [MAX_SPHERES];
  logic [SPH_W-1:0]        rd_q;
  logic                    rd_valid;
  logic signed [BOX_W-1:0] nb_lo [3];
  logic signed [BOX_W-1:0] nb_hi [3];
  logic signed [BOX_W-1:0] sd_lo [2][3];
  logic signed [BOX_W-1:0] sd_hi [2][3];
  logic [CNT_W-1:0]        sd_cnt [2];
  logic [AREA_W-1:0]       area [2];
  logic [COST_W-1:0]       cost_part [2];
  logic signed [CMP_W-1:0] pos;
  logic [COST_W-1:0]       low_cost;
  logic [AXIS_W-1:0]       win_axis;
  logic signed [CMP_W-1:0] best_pos;
  logic                    best_found;

  logic                    full, leaf;
  logic signed [CW-1:0]    in_c [3];
  logic signed [CW-1:0]    rd_c [3];
  logic [RAD_W-1:0]        rd_r;
  logic signed [CW-1:0]    c_sel;
  logic signed [CMP_W-1:0] c8, lo_e, ext_e, plane_e, pos_calc;
  logic                    side;
  logic [DIM_W-1:0]        dim [3];
  logic [DIM_W-1:0]        mac_a, mac_b;
  logic [2*DIM_W-1:0]      mac_prod;
  logic [AREA_W+CNT_W-1:0] cprod;
  logic [COST_W-1:0]       total;
  logic                    eligible;

  assign full = (cnt == CNT_W'(MAX_SPHERES));
  assign leaf = (cnt <= CNT_W'(1)) || (depth_held >= max_depth);
  assign st.leaf     = leaf;
  assign st.out_free = !res.valid || res.ready;

  assign in_c[0] = sph.center_x;
  assign in_c[1] = sph.center_y;
  assign in_c[2] = sph.center_z;

  // store word: {z, y, x, radius}
  assign rd_r    = rd_q[RAD_W-1:0];
  assign rd_c[0] = rd_q[RAD_W +: CW];
  assign rd_c[1] = rd_q[RAD_W+CW +: CW];
  assign rd_c[2] = rd_q[RAD_W+2*CW +: CW];

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[cnt[AW-1:0]] <= {sph.center_z, sph.center_y, sph.center_x,
                                                sph.radius};
    if (cmd.rd_en) rd_q <= mem[rd_addr];
  end

  // split plane for the current axis and plane number
  always_comb begin
    lo_e     = CMP_W'(nb_lo[cmd.axis]);
    ext_e    = CMP_W'(nb_hi[cmd.axis]) - CMP_W'(nb_lo[cmd.axis]);
    plane_e  = $signed(CMP_W'(cmd.plane));
    pos_calc = (lo_e <<< BIN_SH) + plane_e * ext_e;
    c_sel    = rd_c[cmd.axis];
    c8       = CMP_W'(c_sel) <<< BIN_SH;
    side     = !(c8 < pos);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dim[a] = DIM_W'(sd_hi[cmd.ev_side][a]) - DIM_W'(sd_lo[cmd.ev_side][a]);
    end
    unique case (cmd.ev_term)
      2'd0:    begin mac_a = dim[0]; mac_b = dim[1]; end
      2'd1:    begin mac_a = dim[1]; mac_b = dim[2]; end
      default: begin mac_a = dim[2]; mac_b = dim[0]; end
    endcase
    mac_prod = mac_a * mac_b;
    cprod    = (AREA_W+CNT_W)'(area[cmd.ev_side]) * (AREA_W+CNT_W)'(sd_cnt[cmd.ev_side]);
    total    = cost_part[0] + cost_part[1];
    eligible = (sd_cnt[0] != '0) && (sd_cnt[1] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= MAX_DEPTH_RST;
    end else if (cfg_wr_en) begin
      max_depth <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      depth_held <= '0;
      rd_valid   <= 1'b0;
      low_cost   <= '1;
      win_axis   <= '0;
      best_pos   <= '0;
      best_found <= 1'b0;
      res.valid  <= 1'b0;
      sd_cnt[0]  <= '0;
      sd_cnt[1]  <= '0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.load && !full) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == '0) depth_held <= sph.node_depth;
        for (int a = 0; a < 3; a++) begin
          if (cnt == '0 || sph_lo(in_c[a], sph.radius) < nb_lo[a])
            nb_lo[a] <= sph_lo(in_c[a], sph.radius);
          if (cnt == '0 || sph_hi(in_c[a], sph.radius) > nb_hi[a])
            nb_hi[a] <= sph_hi(in_c[a], sph.radius);
        end
      end
      if (cmd.plane_start) begin
        pos       <= pos_calc;
        sd_cnt[0] <= '0;
        sd_cnt[1] <= '0;
        area[0]   <= '0;
        area[1]   <= '0;
      end
      if (rd_valid) begin
        sd_cnt[side] <= sd_cnt[side] + CNT_W'(1);
        for (int a = 0; a < 3; a++) begin
          if (sd_cnt[side] == '0 || sph_lo(rd_c[a], rd_r) < sd_lo[side][a])
            sd_lo[side][a] <= sph_lo(rd_c[a], rd_r);
          if (sd_cnt[side] == '0 || sph_hi(rd_c[a], rd_r) > sd_hi[side][a])
            sd_hi[side][a] <= sph_hi(rd_c[a], rd_r);
        end
      end
      unique case (cmd.ev_op)
        EV_MAC:  area[cmd.ev_side] <= area[cmd.ev_side] + AREA_W'(mac_prod);
        EV_COST: cost_part[cmd.ev_side] <= COST_W'({cprod, 1'b0});
        EV_CMP: begin
          if (eligible && total < low_cost) begin
            low_cost   <= total;
            win_axis   <= cmd.axis;
            best_pos   <= pos;
            best_found <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.emit) begin
        res.valid        <= 1'b1;
        res.is_leaf      <= leaf;
        res.split_found  <= !leaf && best_found;
        res.split_axis   <= leaf ? '0 : win_axis;
        res.split_pos_x8 <= leaf ? '0 : best_pos[POS_W-1:0];
        res.box_min_x    <= nb_lo[0];
        res.box_min_y    <= nb_lo[1];
        res.box_min_z    <= nb_lo[2];
        res.box_max_x    <= nb_hi[0];
        res.box_max_y    <= nb_hi[1];
        res.box_max_z    <= nb_hi[2];
        res.node_count   <= CNT_OUT_W'(cnt);
        cnt        <= '0;
        depth_held <= '0;
        low_cost   <= '1;
        win_axis   <= '0;
        best_pos   <= '0;
        best_found <= 1'b0;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SPHERES))
    else $error("sphere count beyond store depth");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(res.valid && !res.ready))
    else $error("result register overwritten");

  a_found_has_cost: assert property (@(posedge clk) disable iff (rst)
    best_found |-> low_cost != '1)
    else $error("split marked found without a cost");

endmodule

// ----- design/bvh_sah_binned_split_select_core.sv -----
// Binned SAH split selection for one BVH node of spheres. Spheres stream in one word
// per cycle while the core is loading and are stored; the word with last set closes
// the node and one result word follows with the node box, sphere count and either a
// leaf mark or the best of 7 planes per axis. For a split node the single read port of
// the sphere store is swept once per candidate plane, followed by a 9-step cost
// evaluation per plane. Spheres past MAX_SPHERES in one node are dropped. A finished
// result waits in the output register while the next node loads.
module bvh_sah_binned_split_select_core import bsah_pkg::*; #(
  parameter int MAX_SPHERES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [DEPTH_W-1:0] cfg_wr_data,
  bsah_in_if.sink            sph,
  bsah_out_if.source         res
);

  localparam int AW    = $clog2(MAX_SPHERES);
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);

  cmd_t             cmd;
  status_t          st;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] cnt;
  logic             in_ready;

  assign sph.ready = in_ready;

  bsah_ctrl #(.AW(AW), .CNT_W(CNT_W)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sph.valid),
    .in_last  (sph.last),
    .in_ready (in_ready),
    .st       (st),
    .cnt      (cnt),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  bsah_dp #(.MAX_SPHERES(MAX_SPHERES), .AW(AW), .CNT_W(CNT_W)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sph         (sph),
    .res         (res),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .st          (st),
    .cnt         (cnt)
  );

endmodule

// ----- sim/bvh_sah_binned_split_select_core_tb.sv -----
`timescale 1ns / 100ps

module bvh_sah_binned_split_select_core_tb;
  import bsah_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int IDLE_LIMIT  = 200000;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [RAD_W-1:0]     rad;
    logic [DEPTH_W-1:0]   depth;
    logic                 last;
  } sphere_word_t;

  typedef struct {
    logic                   is_leaf;
    logic                   split_found;
    logic [AXIS_W-1:0]      split_axis;
    logic [POS_W-1:0]       split_pos_x8;
    logic [BOX_W-1:0]       bmin [3];
    logic [BOX_W-1:0]       bmax [3];
    logic [CNT_OUT_W-1:0]   node_count;
  } node_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [DEPTH_W-1:0] cfg_wr_data = '0;

  bsah_in_if  sph ();
  bsah_out_if res ();

  bvh_sah_binned_split_select_core #(.MAX_SPHERES(STORE_DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sph         (sph),
    .res         (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sphere_word_t  word_q [$];
  node_result_t  split_q [$];
  sphere_word_t  cur_word;
  bit            took;
  bit            calm;
  bit            hold_req;
  int            hold_cnt;
  int            errors;
  int            idle_cycles;

  // predictor state
  logic [DEPTH_W-1:0] depth_limit;
  longint        st_c [STORE_DEPTH][3];
  longint        st_r [STORE_DEPTH];
  int            n_loaded;
  logic [DEPTH_W-1:0] depth_held;
  longint        nb_lo [3];
  longint        nb_hi [3];

  function automatic longint unsigned box_area(longint lo [3], longint hi [3]);
    longint unsigned dx, dy, dz;
    dx = hi[0] - lo[0];
    dy = hi[1] - lo[1];
    dz = hi[2] - lo[2];
    return 2 * (dx * dy + dy * dz + dz * dx);
  endfunction

  task automatic absorb_sphere(input sphere_word_t w);
    longint c [3];
    longint r, pos, ext, best_pos;
    longint sl [2][3];
    longint sh [2][3];
    longint l3 [3];
    longint h3 [3];
    int cnt [2];
    int side, win_axis;
    bit leaf, found;
    longint unsigned cost, low_cost;
    node_result_t e;
    c[0] = w.cx;
    c[1] = w.cy;
    c[2] = w.cz;
    r = w.rad;
    if (n_loaded < STORE_DEPTH) begin
      if (n_loaded == 0) depth_held = w.depth;
      for (int a = 0; a < 3; a++) begin
        if (n_loaded == 0 || c[a] - r < nb_lo[a]) nb_lo[a] = c[a] - r;
        if (n_loaded == 0 || c[a] + r > nb_hi[a]) nb_hi[a] = c[a] + r;
        st_c[n_loaded][a] = c[a];
      end
      st_r[n_loaded] = r;
      n_loaded++;
    end
    if (!w.last) return;
    leaf = (n_loaded <= 1) || (depth_held >= depth_limit);
    found = 1'b0;
    win_axis = 0;
    best_pos = 0;
    low_cost = '1;
    if (!leaf) begin
      for (int a = 0; a < 3; a++) begin
        ext = nb_hi[a] - nb_lo[a];
        for (int i = 1; i < SPLIT_BINS; i++) begin
          pos = SPLIT_BINS * nb_lo[a] + i * ext;
          cnt[0] = 0;
          cnt[1] = 0;
          for (int k = 0; k < n_loaded; k++) begin
            side = (SPLIT_BINS * st_c[k][a] < pos) ? 0 : 1;
            for (int b = 0; b < 3; b++) begin
              if (cnt[side] == 0 || st_c[k][b] - st_r[k] < sl[side][b])
                sl[side][b] = st_c[k][b] - st_r[k];
              if (cnt[side] == 0 || st_c[k][b] + st_r[k] > sh[side][b])
                sh[side][b] = st_c[k][b] + st_r[k];
            end
            cnt[side]++;
          end
          if (cnt[0] == 0 || cnt[1] == 0) continue;
          cost = 0;
          for (int s = 0; s < 2; s++) begin
            l3 = sl[s];
            h3 = sh[s];
            cost += longint'(cnt[s]) * box_area(l3, h3);
          end
          if (cost < low_cost) begin
            low_cost = cost;
            win_axis = a;
            best_pos = pos;
            found = 1'b1;
          end
        end
      end
    end
    e.is_leaf = leaf;
    e.split_found = !leaf && found;
    e.split_axis = leaf ? '0 : AXIS_W'(win_axis);
    e.split_pos_x8 = leaf ? '0 : POS_W'(best_pos);
    for (int a = 0; a < 3; a++) begin
      e.bmin[a] = BOX_W'(nb_lo[a]);
      e.bmax[a] = BOX_W'(nb_hi[a]);
    end
    e.node_count = CNT_OUT_W'(n_loaded);
    split_q.push_back(e);
    n_loaded = 0;
    depth_held = '0;
  endtask

  // driver
  always @(posedge clk) begin
    took = sph.valid && sph.ready;
    if (took) absorb_sphere(cur_word);
  end

  always @(negedge clk) begin
    if (rst) begin
      sph.valid <= 1'b0;
    end else if (!sph.valid || took) begin
      if (word_q.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
        cur_word = word_q.pop_front();
        sph.center_x   <= cur_word.cx;
        sph.center_y   <= cur_word.cy;
        sph.center_z   <= cur_word.cz;
        sph.radius     <= cur_word.rad;
        sph.node_depth <= cur_word.depth;
        sph.last       <= cur_word.last;
        sph.valid      <= 1'b1;
      end else begin
        sph.valid <= 1'b0;
      end
    end
  end

  // sink side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_cnt = 600;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= calm || $urandom_range(99) >= 10;
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    node_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (split_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual is_leaf=%0b count=%0d",
                 $time, res.is_leaf, res.node_count);
        errors++;
      end else begin
        e = split_q.pop_front();
        check_field("is_leaf", e.is_leaf, res.is_leaf);
        check_field("split_found", e.split_found, res.split_found);
        check_field("split_axis", e.split_axis, res.split_axis);
        check_field("split_pos_x8", e.split_pos_x8, $unsigned(res.split_pos_x8));
        check_field("box_min_x", e.bmin[0], $unsigned(res.box_min_x));
        check_field("box_min_y", e.bmin[1], $unsigned(res.box_min_y));
        check_field("box_min_z", e.bmin[2], $unsigned(res.box_min_z));
        check_field("box_max_x", e.bmax[0], $unsigned(res.box_max_x));
        check_field("box_max_y", e.bmax[1], $unsigned(res.box_max_y));
        check_field("box_max_z", e.bmax[2], $unsigned(res.box_max_z));
        check_field("node_count", e.node_count, res.node_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((sph.valid && sph.ready) || (res.valid && res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bvh_sah_binned_split_select_core: mismatch");
      $finish;
    end
  end

  task automatic push_word(int x, int y, int z, int r, int d, bit lst);
    sphere_word_t w;
    w.cx = CW'(x);
    w.cy = CW'(y);
    w.cz = CW'(z);
    w.rad = RAD_W'(r);
    w.depth = DEPTH_W'(d);
    w.last = lst;
    word_q.push_back(w);
  endtask

  // node of n spheres; narrow keeps them clustered so planes separate them
  task automatic push_node(int n, bit narrow, int d);
    for (int k = 0; k < n; k++) begin
      if (narrow)
        push_word($urandom_range(400) - 200, $urandom_range(400) - 200,
                  $urandom_range(400) - 200, $urandom_range(60), d, k == n - 1);
      else
        push_word($urandom, $urandom, $urandom, $urandom_range(32767), d, k == n - 1);
    end
  endtask

  task automatic drain_all();
    while (word_q.size() > 0 || sph.valid || split_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_depth_limit(int v);
    drain_all();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= DEPTH_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    depth_limit = DEPTH_W'(v);
  endtask

  task automatic random_nodes(int words, bit mixed_depth);
    int n, left;
    left = words;
    while (left > 0) begin
      case ($urandom_range(9))
        0: n = 1;
        1: n = $urandom_range(12, 30);
        default: n = $urandom_range(2, 8);
      endcase
      if ($urandom_range(9) == 0) begin
        // coincident centers: no plane separates them
        for (int k = 0; k < n; k++)
          push_word(-5, 17, 300, $urandom_range(100), 3, k == n - 1);
      end else begin
        push_node(n, $urandom_range(3) != 0,
                  mixed_depth ? $urandom_range(63) : $urandom_range(10));
      end
      left -= n;
    end
  endtask

  initial begin
    sph.valid = 1'b0;
    sph.center_x = '0;
    sph.center_y = '0;
    sph.center_z = '0;
    sph.radius = '0;
    sph.node_depth = '0;
    sph.last = 1'b0;
    res.ready = 1'b0;
    depth_limit = MAX_DEPTH_RST;
    n_loaded = 0;
    depth_held = '0;
    errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    took = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset depth limit
    push_word(-32768, 32767, 0, 32767, 0, 1'b1);
    push_word(32767, -32768, -1, 0, 63, 1'b1);
    push_word(-32768, -32768, -32768, 32767, 5, 1'b0);
    push_word(32767, 32767, 32767, 32767, 9, 1'b1);
    push_word(10, 10, 10, 3, 1, 1'b0);
    push_word(10, 10, 10, 7, 1, 1'b1);
    push_word(0, 0, 0, 1, 39, 1'b0);
    push_word(100, -50, 7, 2, 39, 1'b0);
    push_word(-90, 30, 8, 4, 39, 1'b1);
    push_word(0, 0, 0, 1, 40, 1'b0);
    push_word(100, -50, 7, 2, 40, 1'b1);
    push_word(1, 2, 3, 0, 7, 1'b0);
    push_word(1, 2, 3, 0, 7, 1'b0);
    push_word(1, 900, 3, 0, 7, 1'b1);
    push_word(-3, 0, 0, 5, 2, 1'b0);
    push_word(5, 0, 0, 5, 2, 1'b0);
    push_word(-3, 0, 0, 5, 2, 1'b0);
    push_word(5, 0, 0, 5, 2, 1'b1);
    drain_all();

    write_depth_limit(0);
    push_node(3, 1'b1, 0);
    push_node(2, 1'b0, 63);
    random_nodes(60, 1'b1);

    write_depth_limit(63);
    push_node(3, 1'b1, 63);
    push_node(3, 1'b1, 62);
    random_nodes(150, 1'b1);

    // store overflow: last lands on a dropped word
    write_depth_limit(2);
    push_node(STORE_DEPTH + 5, 1'b1, 0);
    drain_all();

    // output held back while small nodes keep arriving
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++) push_node(1, 1'b0, 0);
    drain_all();

    write_depth_limit($urandom_range(1, 62));
    calm = 1'b1;
    random_nodes(150, 1'b1);
    drain_all();
    calm = 1'b0;

    write_depth_limit(MAX_DEPTH_RST);
    random_nodes(100, 1'b0);
    drain_all();
    write_depth_limit($urandom_range(63));
    random_nodes(100, 1'b1);
    drain_all();
    repeat (50) @(posedge clk);

    if (errors == 0) $display("bvh_sah_binned_split_select_core: match");
    else $display("bvh_sah_binned_split_select_core: mismatch");
    $finish;
  end

endmodule
